@@ rtl/ssi_pkg.sv @@
// Shared types and constants for the sorted set insert/lookup core.
package ssi_pkg;

  localparam int KEY_W    = 64;
  localparam int OP_W     = 2;
  localparam int SIZE_W   = 9;
  localparam int RES_W    = SIZE_W + 2;
  localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_TEST  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              full_res;
    logic              found;
  } ssi_res_t;

endpackage

@@ rtl/sorted_set_insert_lookup_core.sv @@
// Clear/no-op go straight to the result; a search passes through SRCH and CMP once per probe.
// An add that inserts also shifts the upper entries up, one entry per cycle, then writes the key.
// One item at a time; the single-read-port key RAM bounds the shift loop.
// Reset clears the count and control; the key RAM is not cleared.
// Top level: stream ports, key RAM, sequencer and output register.
module sorted_set_insert_lookup_core #(
  parameter int CAPACITY = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ssi_pkg::KEY_W-1:0]       s_tdata,  // key
  input  logic [ssi_pkg::OP_W-1:0]        s_tuser,  // opcode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ssi_pkg::M_DATA_W-1:0]    m_tdata   // found, full_res, size[8:0], zero pad
);

  localparam int AW = $clog2(CAPACITY);

  logic                        res_valid;
  logic                        res_ready;
  ssi_pkg::ssi_res_t           res;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ssi_pkg::KEY_W-1:0]   ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [ssi_pkg::KEY_W-1:0]   ram_rdata;

  ssi_ram #(
    .WIDTH (ssi_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ssi_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_key    (s_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= ssi_pkg::M_DATA_W'(res);
    end
  end

endmodule

@@ rtl/ssi_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module ssi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ssi_engine.sv @@
// Sequencer: lower-bound search, shift-up and insert over the key RAM.
module ssi_engine #(
  parameter int CAPACITY = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ssi_pkg::OP_W-1:0]      in_op,
  input  logic [ssi_pkg::KEY_W-1:0]     in_key,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ssi_pkg::ssi_res_t             res,
  output logic                          ram_we,
  output logic [$clog2(CAPACITY)-1:0]   ram_waddr,
  output logic [ssi_pkg::KEY_W-1:0]     ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]   ram_raddr,
  input  logic [ssi_pkg::KEY_W-1:0]     ram_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                  state;
  logic [CW-1:0]               count;
  logic [CW-1:0]               lo;
  logic [CW-1:0]               hi;
  logic [CW-1:0]               mid;
  logic [CW-1:0]               cur;
  logic                        pend;
  logic [AW-1:0]               pend_addr;
  logic                        hit;
  logic                        full;
  logic [ssi_pkg::OP_W-1:0]    op;
  logic [ssi_pkg::KEY_W-1:0]   key;
  logic [CW-1:0]               mid_next;
  logic [CW-1:0]               cur_dec;

  assign mid_next = lo + ((hi - lo) >> 1);
  assign cur_dec  = cur - CNT_ONE;

  assign in_ready      = (state == S_IDLE);
  assign res_valid     = (state == S_DONE);
  assign res.found     = hit;
  assign res.full_res  = full;
  assign res.size      = ssi_pkg::SIZE_W'(count);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    ram_raddr = mid_next[AW-1:0];
    case (state)
      S_SHIFT: begin
        ram_we    = pend;
        ram_raddr = cur_dec[AW-1:0];
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = lo[AW-1:0];
        ram_wdata = key;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op   <= in_op;
            key  <= in_key;
            hit  <= 1'b0;
            full <= 1'b0;
            lo   <= '0;
            hi   <= count;
            if (in_op == ssi_pkg::OP_ADD || in_op == ssi_pkg::OP_TEST) begin
              state <= S_SRCH;
            end else begin
              if (in_op == ssi_pkg::OP_CLEAR) begin
                count <= '0;
              end
              state <= S_DONE;
            end
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid   <= mid_next;
            state <= S_CMP;
          end else if (hit || op != ssi_pkg::OP_ADD) begin
            state <= S_DONE;
          end else if (count >= CAP_CNT) begin
            full  <= 1'b1;
            state <= S_DONE;
          end else begin
            cur   <= count;
            pend  <= 1'b0;
            state <= S_SHIFT;
          end
        end
        S_CMP: begin
          // keys are distinct, so an equal probe is the lower bound itself
          if (ram_rdata < key) begin
            lo <= mid + CNT_ONE;
          end else begin
            hi <= mid;
          end
          if (ram_rdata == key) begin
            hit <= 1'b1;
          end
          state <= S_SRCH;
        end
        S_SHIFT: begin
          // read cur-1 now, write it to cur next cycle
          if (cur > lo) begin
            pend      <= 1'b1;
            pend_addr <= cur[AW-1:0];
            cur       <= cur_dec;
          end else begin
            pend  <= 1'b0;
            state <= S_INS;
          end
        end
        S_INS: begin
          count <= count + CNT_ONE;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/ssi_checker.sv @@
// Port-level checker for the sorted set core, bound to the top level.
module ssi_checker #(
  parameter int CAPACITY = 256
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ssi_pkg::M_DATA_W-1:0]  m_tdata
);

  localparam logic [ssi_pkg::SIZE_W-1:0] CAP_SIZE = ssi_pkg::SIZE_W'(CAPACITY);

  logic                        found;
  logic                        full_res;
  logic [ssi_pkg::SIZE_W-1:0]  size;

  assign found    = m_tdata[0];
  assign full_res = m_tdata[1];
  assign size     = m_tdata[ssi_pkg::SIZE_W+1:2];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result item present after reset");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(found && full_res))
    else $error("found and full both set");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && full_res |-> size == CAP_SIZE)
    else $error("full reported below capacity");

  a_size: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (CAPACITY > 511) || (size <= CAP_SIZE))
    else $error("size above capacity");

endmodule

bind sorted_set_insert_lookup_core ssi_checker #(
  .CAPACITY (CAPACITY)
) u_ssi_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ sim/sorted_set_insert_lookup_core_chk.sv @@
`timescale 1ns / 100ps
// Checker for the sorted set core: tracks the set, predicts each result and compares.
module sorted_set_insert_lookup_core_chk #(
  parameter int CAPACITY = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [ssi_pkg::KEY_W-1:0]    s_tdata,  // key
  input  logic [ssi_pkg::OP_W-1:0]     s_tuser,  // opcode
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [ssi_pkg::M_DATA_W-1:0] m_tdata,  // found, full_res, size[8:0], zero pad
  output int                           fail_count,
  output int                           pending,
  output int                           hit_count,
  output int                           reject_count,
  output int                           result_count
);

  logic [ssi_pkg::KEY_W-1:0] set_keys[$];  // ascending, distinct
  ssi_pkg::ssi_res_t         want_q[$];

  initial begin
    fail_count   = 0;
    hit_count    = 0;
    reject_count = 0;
    result_count = 0;
    pending      = 0;
  end

  // Applies one item to the tracked set and returns the result it should produce.
  function automatic ssi_pkg::ssi_res_t apply_op(input logic [ssi_pkg::OP_W-1:0] op,
                                                 input logic [ssi_pkg::KEY_W-1:0] k);
    ssi_pkg::ssi_res_t r;
    int lo;
    int hi;
    int mid;
    bit hit;
    r   = '0;
    hit = 0;
    if (op == ssi_pkg::OP_ADD || op == ssi_pkg::OP_TEST) begin
      lo = 0;
      hi = set_keys.size();
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (set_keys[mid] < k) lo = mid + 1;
        else hi = mid;
      end
      if (lo < set_keys.size()) hit = (set_keys[lo] == k);
      if (hit) begin
        r.found = 1'b1;
      end else if (op == ssi_pkg::OP_ADD) begin
        if (set_keys.size() >= CAPACITY) r.full_res = 1'b1;
        else set_keys.insert(lo, k);
      end
    end else if (op == ssi_pkg::OP_CLEAR) begin
      set_keys.delete();
    end
    // count wraps at 9 bits for large capacities
    r.size = ssi_pkg::SIZE_W'(set_keys.size());
    return r;
  endfunction

  always @(posedge clk) begin : watch
    ssi_pkg::ssi_res_t want;
    ssi_pkg::ssi_res_t got;
    if (rst) begin
      set_keys.delete();
      want_q.delete();
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) want_q.push_back(apply_op(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got = ssi_pkg::ssi_res_t'(m_tdata[ssi_pkg::RES_W-1:0]);
        result_count++;
        if (want_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with nothing pending: found=%0b full=%0b size=%0d",
                     $realtime, got.found, got.full_res, got.size);
        end else begin
          want = want_q.pop_front();
          if (want.found) hit_count++;
          if (want.full_res) reject_count++;
          if (got.found !== want.found || got.full_res !== want.full_res ||
              got.size !== want.size) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch exp found=%0b full=%0b size=%0d, ",
                        "got found=%0b full=%0b size=%0d"},
                       $realtime, want.found, want.full_res, want.size,
                       got.found, got.full_res, got.size);
          end
        end
      end
      pending <= want_q.size();
    end
  end

endmodule

@@ sim/sorted_set_insert_lookup_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the sorted set core: clock, reset, stimulus, handshakes and verdict.
module sorted_set_insert_lookup_core_tb;

  localparam int                        CAPACITY  = 256;
  localparam int                        NUM_ITEMS = 1550;
  localparam logic [ssi_pkg::OP_W-1:0]  OP_NOP    = 2'd3;
  localparam logic [ssi_pkg::KEY_W-1:0] KEY_MAX   = '1;

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [ssi_pkg::KEY_W-1:0]    s_tdata;
  logic [ssi_pkg::OP_W-1:0]     s_tuser;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [ssi_pkg::M_DATA_W-1:0] m_tdata;

  int fail_count;
  int pending;
  int hit_count;
  int reject_count;
  int result_count;
  int items_sent;
  bit src_burst;
  bit sink_burst;
  logic [ssi_pkg::KEY_W-1:0] recent_keys[32];

  sorted_set_insert_lookup_core #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sorted_set_insert_lookup_core_chk #(.CAPACITY(CAPACITY)) chk (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .hit_count    (hit_count),
    .reject_count (reject_count),
    .result_count (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // timeout for the whole run, with ample room for the worst case under receiver stalls
  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

  // valid stays high between back-to-back items; only lowered before a gap
  task automatic send_item(input logic [ssi_pkg::OP_W-1:0] op,
                           input logic [ssi_pkg::KEY_W-1:0] k);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= k;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    recent_keys[items_sent % 32] = k;
    items_sent++;
  endtask

  function automatic logic [ssi_pkg::KEY_W-1:0] pick_key(input bit fill);
    int r;
    r = $urandom_range(0, 99);
    if (fill) begin
      if (r < 75) return {$urandom, $urandom};
      if (r < 95) return recent_keys[$urandom_range(0, 31)];
      return (r < 97) ? ssi_pkg::KEY_W'($urandom_range(0, 3))
                      : KEY_MAX - ssi_pkg::KEY_W'($urandom_range(0, 3));
    end
    if (r < 40) return ssi_pkg::KEY_W'($urandom_range(0, 15));
    if (r < 50) return KEY_MAX - ssi_pkg::KEY_W'($urandom_range(0, 3));
    if (r < 80) return recent_keys[$urandom_range(0, 31)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ssi_pkg::OP_W-1:0] pick_op(input bit fill);
    int r;
    r = $urandom_range(0, 99);
    if (fill) begin
      if (r < 85) return ssi_pkg::OP_ADD;
      if (r < 97) return ssi_pkg::OP_TEST;
      return OP_NOP;
    end
    if (r < 45) return ssi_pkg::OP_ADD;
    if (r < 80) return ssi_pkg::OP_TEST;
    if (r < 90) return ssi_pkg::OP_CLEAR;
    return OP_NOP;
  endfunction

  // Receiver: random stalls per item, burst stretches, and two long hold-offs.
  initial begin : sink
    int w;
    int taken;
    taken    = 0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 64 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      if (taken == 30 || taken == 700) begin
        m_tready <= 1'b0;
        repeat (1200) @(posedge clk);
      end
      w = sink_burst ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stim
    int  seg;
    int  len;
    bit  fill;
    items_sent = 0;
    src_burst  = 0;
    foreach (recent_keys[i]) recent_keys[i] = '0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= ssi_pkg::OP_ADD;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty set, extreme keys, hits, inserts in the middle and at the front
    send_item(ssi_pkg::OP_CLEAR, '0);
    send_item(ssi_pkg::OP_TEST,  '0);
    send_item(ssi_pkg::OP_ADD,   '0);
    send_item(ssi_pkg::OP_ADD,   KEY_MAX);
    send_item(ssi_pkg::OP_ADD,   '0);
    send_item(ssi_pkg::OP_TEST,  KEY_MAX);
    send_item(ssi_pkg::OP_TEST,  64'd5);
    send_item(ssi_pkg::OP_ADD,   64'd5);
    send_item(ssi_pkg::OP_ADD,   64'd3);
    send_item(ssi_pkg::OP_ADD,   KEY_MAX - 1);
    send_item(OP_NOP,            64'hA5A5_5A5A_F0F0_0F0F);
    send_item(ssi_pkg::OP_ADD,   64'h8000_0000_0000_0000);
    send_item(ssi_pkg::OP_TEST,  64'd3);
    send_item(ssi_pkg::OP_TEST,  64'd4);
    send_item(ssi_pkg::OP_ADD,   KEY_MAX);
    send_item(ssi_pkg::OP_CLEAR, KEY_MAX);
    send_item(ssi_pkg::OP_TEST,  '0);
    send_item(ssi_pkg::OP_ADD,   64'd1);
    send_item(ssi_pkg::OP_ADD,   '0);
    send_item(OP_NOP,            KEY_MAX);
    send_item(ssi_pkg::OP_TEST,  64'd1);

    // random: first segment is a long add-heavy fill, later ones mix churn and fills
    seg = 0;
    while (items_sent < NUM_ITEMS) begin
      fill      = (seg == 0) || ($urandom_range(0, 4) == 0);
      len       = fill ? $urandom_range(330, 400) : $urandom_range(15, 60);
      src_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len && items_sent < NUM_ITEMS; i++)
        send_item(pick_op(fill), pick_key(fill));
      seg++;
    end
    s_tvalid <= 1'b0;

    // let the checker count the last accepted item before waiting on it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d items in %0d random segments, checked %0d results.",
             items_sent, seg, result_count);
    $display("Keys already present: %0d, adds rejected on a full store: %0d, mismatches: %0d.",
             hit_count, reject_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
